FILE: rtl/core/assert_macros.svh
// Concurrent assertion helpers, clocked on clock and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/tked_pkg.sv
package tked_pkg;

   localparam int ByteW = 8;

   localparam logic [ByteW-1:0] BYTE_ESC   = 8'd27;
   localparam logic [ByteW-1:0] BYTE_BKSP  = 8'd127;
   localparam logic [ByteW-1:0] BYTE_CSI   = 8'h5B; // '['
   localparam logic [ByteW-1:0] BYTE_SS3   = 8'h4F; // 'O'
   localparam logic [ByteW-1:0] BYTE_TILDE = 8'h7E; // '~'
   localparam logic [ByteW-1:0] BYTE_SEMI  = 8'h3B; // ';'

   localparam logic [ByteW-1:0] K_ESC   = 8'd0;
   localparam logic [ByteW-1:0] K_BKSP  = 8'd1;
   localparam logic [ByteW-1:0] K_UP    = 8'd2;
   localparam logic [ByteW-1:0] K_HOME  = 8'd6;
   localparam logic [ByteW-1:0] K_END   = 8'd7;
   localparam logic [ByteW-1:0] K_DEL   = 8'd8;
   localparam logic [ByteW-1:0] K_PGUP  = 8'd9;
   localparam logic [ByteW-1:0] K_PGDN  = 8'd10;
   localparam logic [ByteW-1:0] K_F1    = 8'd11;
   localparam logic [ByteW-1:0] K_F9    = 8'd19;
   localparam logic [ByteW-1:0] K_F10   = 8'd20;
   localparam logic [ByteW-1:0] K_UNK1  = 8'd21;
   localparam logic [ByteW-1:0] K_UNK2  = 8'd22;
   localparam logic [ByteW-1:0] K_UNK3  = 8'd23;
   localparam logic [ByteW-1:0] K_UNK4  = 8'd24;
   localparam logic [ByteW-1:0] K_UNK5  = 8'd25;
   localparam logic [ByteW-1:0] K_UNK6  = 8'd26;
   localparam logic [ByteW-1:0] K_UNK7  = 8'd27;

   // final byte after ESC [ d
   function automatic logic [ByteW-1:0] csi_digit_key(input logic [ByteW-1:0] d,
                                                      input logic [ByteW-1:0] b);
      logic tl;
      logic [ByteW-1:0] key;
      tl = (b == BYTE_TILDE);
      case (d)
         8'h32: key = (b == 8'h30) ? K_F9 : ((b == 8'h31) ? K_F10 : K_UNK1);
         8'h33: key = tl ? K_DEL  : K_UNK1;
         8'h34: key = tl ? K_END  : K_UNK2;
         8'h35: key = tl ? K_PGUP : K_UNK3;
         default: key = tl ? K_PGDN : K_UNK4;
      endcase
      return key;
   endfunction

   // byte after ESC O
   function automatic logic [ByteW-1:0] ss3_key(input logic [ByteW-1:0] b);
      logic [ByteW-1:0] key;
      case (b)
         8'h48: key = K_HOME;
         8'h46: key = K_END;
         8'h50, 8'h51, 8'h52, 8'h53: key = K_F1 + (b - 8'h50);
         default: key = K_UNK6;
      endcase
      return key;
   endfunction

endpackage

FILE: rtl/core/terminal_key_escape_decoder.sv
// Terminal key decoder: takes one request per cycle (a received byte, or a read
// timeout when req_tuser is high) and turns VT100/xterm escape sequences into
// key ids, byte 127 into backspace and other bytes into raw characters. A
// request gives zero or one result; rsp_tuser is high when rsp_tdata is a key
// id. Each request passes an input register, a combinational decode against
// the parser state, and a result register, so a new request is taken every
// cycle while the result side keeps up; a stalled result holds off the input
// only once both registers are full.
`include "assert_macros.svh"

module terminal_key_escape_decoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [tked_pkg::ByteW-1:0] req_tdata,  // [7:0] in_byte
   input  logic                       req_tuser,  // [0] op (1 = timeout)
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [tked_pkg::ByteW-1:0] rsp_tdata,  // [7:0] code
   output logic                       rsp_tuser   // [0] is_key
);
   import tked_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_ESC1 = 3'd1,
      PH_ESC2 = 3'd2,
      PH_CSIN = 3'd3,
      PH_ONEA = 3'd4,
      PH_ONEB = 3'd5,
      PH_SEMI = 3'd6
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [ByteW-1:0] lead_ff, lead_in;
   logic [ByteW-1:0] held_ff, held_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [ByteW-1:0] s1_byte_ff, s1_byte_in;
   logic             s1_tmo_ff, s1_tmo_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ByteW-1:0] rsp_code_ff, rsp_code_in;
   logic             rsp_key_ff, rsp_key_in;

   logic             out_free;
   logic             step;
   logic             emit;
   logic             emit_key;
   logic [ByteW-1:0] emit_code;
   logic [ByteW-1:0] b;
   logic             tmo;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_code_ff;
   assign rsp_tuser  = rsp_key_ff;
   assign b          = s1_byte_ff;
   assign tmo        = s1_tmo_ff;

   // parser step for the item in the input register
   always_comb begin
      phase_in  = phase_ff;
      lead_in   = lead_ff;
      held_in   = held_ff;
      emit      = 1'b0;
      emit_key  = 1'b1;
      emit_code = K_ESC;
      case (phase_ff)
         PH_ESC1: begin
            if (tmo) begin
               emit = 1'b1;
               emit_code = K_ESC;
            end else begin
               lead_in  = b;
               phase_in = PH_ESC2;
            end
         end
         PH_ESC2: begin
            emit = 1'b1;
            if (tmo) begin
               emit_code = K_UNK1;
            end else if (lead_ff == BYTE_CSI) begin
               if (b == 8'h31) begin
                  emit     = 1'b0;
                  phase_in = PH_ONEA;
               end else if (b >= 8'h32 && b <= 8'h36) begin
                  emit     = 1'b0;
                  held_in  = b;
                  phase_in = PH_CSIN;
               end else if (b >= 8'h41 && b <= 8'h44) begin
                  emit_code = K_UP + (b - 8'h41);
               end else begin
                  emit_code = K_UNK5;
               end
            end else if (lead_ff == BYTE_SS3) begin
               emit_code = ss3_key(b);
            end else begin
               emit_code = K_UNK7;
            end
         end
         PH_CSIN: begin
            emit      = 1'b1;
            emit_code = tmo ? K_ESC : csi_digit_key(held_ff, b);
         end
         PH_ONEA: begin
            if (tmo) begin
               emit = 1'b1;
               emit_code = K_UNK1;
            end else begin
               held_in  = b;
               phase_in = PH_ONEB;
            end
         end
         PH_ONEB: begin
            // this byte (or timeout) is dropped; the held byte decides
            emit = 1'b1;
            case (held_ff)
               8'h35: emit_code = K_F1 + 8'd4;
               8'h37: emit_code = K_F1 + 8'd5;
               8'h38: emit_code = K_F1 + 8'd6;
               8'h39: emit_code = K_F1 + 8'd7;
               BYTE_TILDE: emit_code = K_HOME;
               BYTE_SEMI: begin
                  emit     = 1'b0;
                  phase_in = PH_SEMI;
               end
               default: begin
                  emit     = 1'b0;
                  phase_in = PH_ESC1;
               end
            endcase
         end
         PH_SEMI: begin
            emit = 1'b1;
            if (tmo)            emit_code = K_UNK1;
            else if (b == 8'h41) emit_code = K_PGUP;
            else if (b == 8'h42) emit_code = K_PGDN;
            else                emit_code = K_UNK2;
         end
         default: begin
            phase_in = PH_IDLE;
            if (!tmo) begin
               if (b == BYTE_ESC) begin
                  phase_in = PH_ESC1;
               end else if (b == BYTE_BKSP) begin
                  emit = 1'b1;
                  emit_code = K_BKSP;
               end else begin
                  emit = 1'b1;
                  emit_key = 1'b0;
                  emit_code = b;
               end
            end
         end
      endcase
      if (emit) begin
         phase_in = PH_IDLE;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_tmo_in   = s1_tmo_ff;
      if (step) begin
         s1_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_tdata;
         s1_tmo_in   = req_tuser;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_code_in  = rsp_code_ff;
      rsp_key_in   = rsp_key_ff;
      if (step && emit) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = emit_code;
         rsp_key_in   = emit_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         lead_ff      <= '0;
         held_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
            lead_ff  <= lead_in;
            held_ff  <= held_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_byte_ff  <= s1_byte_in;
      s1_tmo_ff   <= s1_tmo_in;
      rsp_code_ff <= rsp_code_in;
      rsp_key_ff  <= rsp_key_in;
   end

   `ASSERT_NEXT(a_s1_held, s1_valid_ff && !out_free, s1_valid_ff && $stable(s1_byte_ff), "input item lost")
   `ASSERT_NEXT(a_emit_out, step && emit, rsp_valid_ff && rsp_code_ff == $past(emit_code), "result lost")
   `ASSERT_NEXT(a_emit_idle, step && emit, phase_ff == PH_IDLE, "parser not idle after result")
   `ASSERT_CLK(a_raw_char, !(rsp_valid_ff && !rsp_key_ff && (rsp_code_ff == BYTE_ESC || rsp_code_ff == BYTE_BKSP)), "ESC or DEL passed as raw")

endmodule

FILE: tb/terminal_key_escape_decoder_tb.sv
`timescale 1ns / 1ps

module terminal_key_escape_decoder_tb;
   import tked_pkg::*;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TMO  = 1'b1;

   localparam int N_RANDOM    = 1200;
   localparam int STEADY_REQS = 250;
   localparam int HOLD_AT     = 700;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 5000;
   localparam int DRAIN       = 10;

   typedef logic [8:0] req_word_type;  // {op, in_byte}

   typedef struct packed {
      logic             is_key;
      logic [ByteW-1:0] code;
   } key_type;

   typedef enum logic [2:0] {
      PH_IDLE, PH_ESC1, PH_ESC2, PH_CSIN, PH_ONEA, PH_ONEB, PH_SEMI
   } phase_type;

   typedef struct {
      req_word_type w;
      bit           typed;
      bit           t_has;
      key_type      t_key;
   } dir_row_type;

   localparam req_word_type W_ESC = {OP_BYTE, BYTE_ESC};
   localparam req_word_type W_CSI = {OP_BYTE, BYTE_CSI};
   localparam req_word_type W_TMO = {OP_TMO, 8'h00};
   localparam key_type      NO_KEY = '0;
   localparam bit           CHK = 1'b1;
   localparam bit           PRD = 1'b0;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [ByteW-1:0] req_tdata = '0;
   logic             req_tuser = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [ByteW-1:0] rsp_tdata;
   logic             rsp_tuser;

   bit      steady = 1'b1;
   bit      hold_rsp = 1'b0;
   int      fails = 0;
   int      quiet_cycles = 0;
   key_type keys_due [$];
   key_type due_key;

   phase_type        ph = PH_IDLE;
   logic [ByteW-1:0] lead_b = '0;
   logic [ByteW-1:0] held_b = '0;

   dir_row_type dir_tab [32] = '{
      '{{OP_BYTE, 8'h00},     CHK, 1'b1, {1'b0, 8'h00}},
      '{{OP_BYTE, 8'hFF},     CHK, 1'b1, {1'b0, 8'hFF}},
      '{{OP_BYTE, BYTE_BKSP}, CHK, 1'b1, {1'b1, K_BKSP}},
      '{W_TMO,                CHK, 1'b0, NO_KEY},
      // ESC [ 2, timeout
      '{W_ESC,                PRD, 1'b0, NO_KEY},
      '{W_CSI,                PRD, 1'b0, NO_KEY},
      '{{OP_BYTE, "2"},       PRD, 1'b0, NO_KEY},
      '{W_TMO,                CHK, 1'b1, {1'b1, K_ESC}},
      // ESC [ 1, timeout
      '{W_ESC,                PRD, 1'b0, NO_KEY},
      '{W_CSI,                PRD, 1'b0, NO_KEY},
      '{{OP_BYTE, "1"},       PRD, 1'b0, NO_KEY},
      '{W_TMO,                CHK, 1'b1, {1'b1, K_UNK1}},
      // ESC [ 1 ; with the dropped byte as a timeout, then timeout
      '{W_ESC,                PRD, 1'b0, NO_KEY},
      '{W_CSI,                PRD, 1'b0, NO_KEY},
      '{{OP_BYTE, "1"},       PRD, 1'b0, NO_KEY},
      '{{OP_BYTE, BYTE_SEMI}, PRD, 1'b0, NO_KEY},
      '{W_TMO,                PRD, 1'b0, NO_KEY},
      '{W_TMO,                CHK, 1'b1, {1'b1, K_UNK1}},
      // ESC [ 1 z y restarts at ESC, then timeout
      '{W_ESC,                PRD, 1'b0, NO_KEY},
      '{W_CSI,                PRD, 1'b0, NO_KEY},
      '{{OP_BYTE, "1"},       PRD, 1'b0, NO_KEY},
      '{{OP_BYTE, "z"},       PRD, 1'b0, NO_KEY},
      '{{OP_BYTE, "y"},       PRD, 1'b0, NO_KEY},
      '{W_TMO,                CHK, 1'b1, {1'b1, K_ESC}},
      // ESC x, timeout
      '{W_ESC,                PRD, 1'b0, NO_KEY},
      '{{OP_BYTE, "x"},       PRD, 1'b0, NO_KEY},
      '{W_TMO,                CHK, 1'b1, {1'b1, K_UNK1}},
      // ESC [ 2 1 ends without '~'; the '~' comes out raw
      '{W_ESC,                PRD, 1'b0, NO_KEY},
      '{W_CSI,                PRD, 1'b0, NO_KEY},
      '{{OP_BYTE, "2"},       PRD, 1'b0, NO_KEY},
      '{{OP_BYTE, "1"},       PRD, 1'b0, NO_KEY},
      '{{OP_BYTE, BYTE_TILDE}, PRD, 1'b0, NO_KEY}
   };

   terminal_key_escape_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Decodes one request against the parser state; returns 1 when a result comes out.
   function automatic logic decode_key(input logic tmo, input logic [ByteW-1:0] b,
                                       output key_type k);
      int   kc;
      logic raw;
      kc = -1;
      raw = 1'b0;
      k = '0;
      case (ph)
         PH_ESC1: begin
            if (tmo) kc = K_ESC;
            else begin
               lead_b = b;
               ph = PH_ESC2;
            end
         end
         PH_ESC2: begin
            if (tmo) kc = K_UNK1;
            else if (lead_b == BYTE_CSI) begin
               if (b == "1") ph = PH_ONEA;
               else if (b >= "2" && b <= "6") begin
                  held_b = b;
                  ph = PH_CSIN;
               end else if (b >= "A" && b <= "D") kc = K_UP + (b - "A");
               else kc = K_UNK5;
            end else if (lead_b == BYTE_SS3) begin
               case (b)
                  "H": kc = K_HOME;
                  "F": kc = K_END;
                  "P", "Q", "R", "S": kc = K_F1 + (b - "P");
                  default: kc = K_UNK6;
               endcase
            end else kc = K_UNK7;
         end
         PH_CSIN: begin
            if (tmo) kc = K_ESC;
            else begin
               case (held_b)
                  "2": kc = (b == "0") ? K_F9 : ((b == "1") ? K_F10 : K_UNK1);
                  "3": kc = (b == BYTE_TILDE) ? K_DEL : K_UNK1;
                  "4": kc = (b == BYTE_TILDE) ? K_END : K_UNK2;
                  "5": kc = (b == BYTE_TILDE) ? K_PGUP : K_UNK3;
                  default: kc = (b == BYTE_TILDE) ? K_PGDN : K_UNK4;
               endcase
            end
         end
         PH_ONEA: begin
            if (tmo) kc = K_UNK1;
            else begin
               held_b = b;
               ph = PH_ONEB;
            end
         end
         PH_ONEB: begin
            // byte (or timeout) here is dropped
            case (held_b)
               "5": kc = K_F1 + 4;
               "7": kc = K_F1 + 5;
               "8": kc = K_F1 + 6;
               "9": kc = K_F1 + 7;
               BYTE_TILDE: kc = K_HOME;
               BYTE_SEMI: ph = PH_SEMI;
               default: ph = PH_ESC1;
            endcase
         end
         PH_SEMI: begin
            if (tmo) kc = K_UNK1;
            else if (b == "A") kc = K_PGUP;
            else if (b == "B") kc = K_PGDN;
            else kc = K_UNK2;
         end
         default: begin
            ph = PH_IDLE;
            if (!tmo) begin
               if (b == BYTE_ESC) ph = PH_ESC1;
               else if (b == BYTE_BKSP) kc = K_BKSP;
               else begin
                  raw = 1'b1;
                  kc = b;
               end
            end
         end
      endcase
      if (kc < 0) return 1'b0;
      k.is_key = !raw;
      k.code = kc[ByteW-1:0];
      ph = PH_IDLE;
      return 1'b1;
   endfunction

   function automatic logic [ByteW-1:0] pick(input string s);
      if ($urandom_range(4) == 0) return 8'($urandom);
      return s[$urandom_range(s.len() - 1)];
   endfunction

   task automatic send_req(input req_word_type w, output logic got, output key_type k);
      while (!steady && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= w[8];
      req_tdata <= w[7:0];
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      got = decode_key(w[8], w[7:0], k);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp_tready <= steady || ($urandom_range(99) >= 15);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (keys_due.size() == 0) begin
               $error("unexpected result: is_key %0d code %0d", rsp_tuser, rsp_tdata);
               fails++;
            end else begin
               due_key = keys_due.pop_front();
               if (rsp_tuser !== due_key.is_key) begin
                  $error("is_key: expected %0d, got %0d", due_key.is_key, rsp_tuser);
                  fails++;
               end
               if (rsp_tdata !== due_key.code) begin
                  $error("code: expected %0d, got %0d", due_key.code, rsp_tdata);
                  fails++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin
      req_word_type     burst [$];
      req_word_type     w;
      logic             got;
      key_type          k;
      logic [ByteW-1:0] x;
      int               sent;
      bit               hold_done;
      sent = 0;
      hold_done = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         send_req(dir_tab[i].w, got, k);
         if (dir_tab[i].typed) begin
            if (dir_tab[i].t_has) keys_due.push_back(dir_tab[i].t_key);
         end else if (got) begin
            keys_due.push_back(k);
         end
      end

      while (sent < N_RANDOM) begin
         steady = (sent < STEADY_REQS);
         if (sent >= HOLD_AT && !hold_done) begin
            hold_rsp = 1'b1;
            hold_done = 1'b1;
         end
         burst.delete();
         case ($urandom_range(15))
            0, 1, 2: burst.push_back({OP_BYTE, 8'($urandom)});
            3: burst.push_back({OP_BYTE, BYTE_BKSP});
            4, 5: begin
               burst.push_back(W_ESC);
               burst.push_back(W_CSI);
               burst.push_back({OP_BYTE, pick("ABCD")});
            end
            6, 7: begin
               burst.push_back(W_ESC);
               burst.push_back(W_CSI);
               burst.push_back({OP_BYTE, pick("23456")});
               burst.push_back({OP_BYTE, pick("~~~01")});
            end
            8, 9: begin
               x = pick("5789~;");
               burst.push_back(W_ESC);
               burst.push_back(W_CSI);
               burst.push_back({OP_BYTE, 8'("1")});
               burst.push_back({OP_BYTE, x});
               burst.push_back({1'($urandom_range(1)), 8'($urandom)});
               if (x == BYTE_SEMI) burst.push_back({OP_BYTE, pick("AB")});
            end
            10, 11: begin
               burst.push_back(W_ESC);
               burst.push_back({OP_BYTE, BYTE_SS3});
               burst.push_back({OP_BYTE, pick("HFPQRS")});
            end
            12: begin
               burst.push_back(W_ESC);
               burst.push_back({OP_BYTE, 8'($urandom)});
               burst.push_back({OP_BYTE, 8'($urandom)});
            end
            13: begin
               burst.push_back(W_ESC);
               if ($urandom_range(1)) begin
                  burst.push_back(W_CSI);
                  if ($urandom_range(1)) burst.push_back({OP_BYTE, pick("123456")});
               end
               burst.push_back({OP_TMO, 8'($urandom)});
            end
            14: begin
               repeat (3) burst.push_back({1'($urandom_range(1)), 8'($urandom)});
            end
            default: burst.push_back({OP_TMO, 8'($urandom)});
         endcase
         foreach (burst[i]) begin
            w = burst[i];
            if ($urandom_range(19) == 0) w = {OP_TMO, w[7:0]};
            send_req(w, got, k);
            if (got) keys_due.push_back(k);
            sent++;
         end
      end

      req_tvalid <= 1'b0;
      while (keys_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (fails == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/tked_pkg.sv
rtl/core/terminal_key_escape_decoder.sv
tb/terminal_key_escape_decoder_tb.sv
